// ----- rtl/clbs_pkg.sv -----
// Shared types, codes and constants for the character LCD bus sequencer.
// Depends on nothing; every other file in the block imports it.
`timescale 1ns / 1ps

package clbs_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_DATA   = 3'd2;
    localparam logic [2:0] REQ_CURSOR = 3'd3;
    localparam logic [2:0] REQ_INIT   = 3'd4;

    localparam logic [1:0] REG_SETUP   = 2'd0;
    localparam logic [1:0] REG_PULSE   = 2'd1;
    localparam logic [1:0] REG_POWER   = 2'd2;
    localparam logic [1:0] REG_GAP     = 2'd3;

    localparam logic [15:0] SETUP_RESET = 16'd72;
    localparam logic [15:0] PULSE_RESET = 16'd72;
    localparam logic [23:0] POWER_RESET = 24'd720000;
    localparam logic [23:0] GAP_RESET   = 24'd360000;

    localparam logic [7:0] CMD_ROW0 = 8'h80;
    localparam logic [7:0] CMD_ROW1 = 8'hC0;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic       row;
        logic       busy_bit;
    } clbs_req_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_not_write;
        logic       enable_pin;
        logic [7:0] bus_byte;
        logic       bus_drive;
        logic       idle;
        logic       rejected;
    } clbs_rsp_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_INIT,
        KIND_NONE
    } clbs_kind_t;

    typedef struct packed {
        clbs_kind_t kind;
        logic [7:0] wr_byte;
        logic       wr_rs;
        logic       busy;
    } clbs_cmd_t;

    typedef struct packed {
        logic [15:0] setup_ticks;
        logic [15:0] pulse_ticks;
        logic [23:0] power_up_ticks;
        logic [23:0] init_gap_ticks;
    } clbs_cfg_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h38;
            3'd1:    val = 8'h38;
            3'd2:    val = 8'h08;
            3'd3:    val = 8'h01;
            3'd4:    val = 8'h06;
            3'd5:    val = 8'h0C;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/char_lcd_bus_sequencer_unit.sv -----
// Top level of the character LCD bus sequencer: register port, front end and
// back end. Depends on clbs_pkg, clbs_regs, clbs_front and clbs_back.
//
//   Channel   Handshake            Payload
//   request   push / full          req  (clbs_req_t)
//   result    pop / empty          rsp  (clbs_rsp_t)
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// One word is taken every clock while full is low; the sequencer handles one word
// a cycle while the result queue has room. A word's result reaches the result
// ports through the command queue and the result queue, each two entries deep.
// Reset clears both queues and puts the pins at RS high, all else low.
// Holding pop low fills the result queue, then the command queue, then raises full.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_unit
    import clbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  clbs_req_t         req,
    output logic              empty,
    input  logic              pop,
    output clbs_rsp_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    clbs_cfg_t cfg;
    logic      cmd_valid;
    clbs_cmd_t cmd;
    logic      cmd_take;

    clbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    clbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/clbs_regs.sv -----
// Configuration registers of the LCD bus sequencer behind an APB-style port.
// Depends on clbs_pkg.
`timescale 1ns / 1ps

module clbs_regs
    import clbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output clbs_cfg_t         cfg
);

    clbs_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks    <= SETUP_RESET;
            cfg_reg.pulse_ticks    <= PULSE_RESET;
            cfg_reg.power_up_ticks <= POWER_RESET;
            cfg_reg.init_gap_ticks <= GAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SETUP: cfg_reg.setup_ticks    <= pwdata[15:0];
                REG_PULSE: cfg_reg.pulse_ticks    <= pwdata[15:0];
                REG_POWER: cfg_reg.power_up_ticks <= pwdata[23:0];
                REG_GAP:   cfg_reg.init_gap_ticks <= pwdata[23:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SETUP: prdata = {16'd0, cfg_reg.setup_ticks};
            REG_PULSE: prdata = {16'd0, cfg_reg.pulse_ticks};
            REG_POWER: prdata = {8'd0, cfg_reg.power_up_ticks};
            REG_GAP:   prdata = {8'd0, cfg_reg.init_gap_ticks};
        endcase
    end

endmodule

// ----- rtl/clbs_front.sv -----
// Front end: decodes each incoming word into a command and holds it in a
// two-entry queue for the sequencer. Depends on clbs_pkg.
`timescale 1ns / 1ps

module clbs_front
    import clbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  clbs_req_t req,
    output logic      cmd_valid,
    output clbs_cmd_t cmd,
    input  logic      cmd_take
);

    clbs_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       take;
    clbs_cmd_t  dec;

    always_comb
    begin
        dec.wr_byte = req.byte_value;
        dec.wr_rs   = 1'b0;
        dec.busy    = req.busy_bit;
        unique case (req.req_type)
            REQ_TICK:   dec.kind = KIND_TICK;
            REQ_CMD:    dec.kind = KIND_WRITE;
            REQ_DATA:
            begin
                dec.kind  = KIND_WRITE;
                dec.wr_rs = 1'b1;
            end
            REQ_CURSOR:
            begin
                dec.kind    = KIND_WRITE;
                dec.wr_byte = (req.row ? CMD_ROW1 : CMD_ROW0) + {2'b00, req.column};
            end
            REQ_INIT:   dec.kind = KIND_INIT;
            default:    dec.kind = KIND_NONE;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign take      = cmd_valid && cmd_take;
    assign cmd       = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, accept} - {1'b0, take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- rtl/clbs_back.sv -----
// Back end: the bus sequencer state machine and its two-entry result queue.
// Depends on clbs_pkg.
`timescale 1ns / 1ps

module clbs_back
    import clbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  clbs_cfg_t cfg,
    input  logic      cmd_valid,
    input  clbs_cmd_t cmd,
    output logic      cmd_take,
    output logic      empty,
    input  logic      pop,
    output clbs_rsp_t rsp
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER,
        PH_GAP,
        PH_POLL,
        PH_SETUP,
        PH_PULSE
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [23:0] tick_count_reg;
    logic [23:0] tick_count_next;
    logic [7:0]  pending_byte_reg;
    logic [7:0]  pending_byte_next;
    logic        pending_rs_reg;
    logic        pending_rs_next;
    logic [2:0]  init_step_reg;
    logic [2:0]  init_step_next;
    logic        rs_reg;
    logic        rs_next;
    logic        rw_reg;
    logic        rw_next;
    logic        en_reg;
    logic        en_next;
    logic        drv_reg;
    logic        drv_next;
    logic [7:0]  pin_byte_reg;
    logic [7:0]  pin_byte_next;

    clbs_rsp_t   res_reg [2];
    logic        res_wr_reg;
    logic        res_rd_reg;
    logic [1:0]  res_count_reg;
    logic [1:0]  res_count_next;
    logic        res_pop;

    logic        step;
    logic        rejected;
    logic        sw;
    logic [7:0]  sw_byte;
    logic [23:0] cnt_inc;
    logic [23:0] wait_len;
    logic        done;
    clbs_rsp_t   res_new;

    assign step     = cmd_valid && (res_count_reg != 2'd2);
    assign cmd_take = step;
    assign cnt_inc  = tick_count_reg + 24'd1;
    assign done     = (cnt_inc >= wait_len);

    always_comb
    begin
        unique case (phase_reg)
            PH_POWER: wait_len = cfg.power_up_ticks;
            PH_GAP:   wait_len = cfg.init_gap_ticks;
            PH_SETUP: wait_len = {8'd0, cfg.setup_ticks};
            default:  wait_len = {8'd0, cfg.pulse_ticks};
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        pending_byte_next = pending_byte_reg;
        pending_rs_next   = pending_rs_reg;
        init_step_next    = init_step_reg;
        rs_next           = rs_reg;
        rw_next           = rw_reg;
        en_next           = en_reg;
        drv_next          = drv_reg;
        pin_byte_next     = pin_byte_reg;
        rejected          = 1'b0;
        sw                = 1'b0;
        sw_byte           = cmd.wr_byte;
        if (step)
        begin
            unique case (cmd.kind)
                KIND_TICK:
                begin
                    unique case (phase_reg)
                        PH_POWER:
                        begin
                            tick_count_next = cnt_inc;
                            if (done)
                            begin
                                init_step_next = 3'd1;
                                sw             = 1'b1;
                                sw_byte        = init_cmd(3'd0);
                            end
                        end
                        PH_GAP:
                        begin
                            tick_count_next = cnt_inc;
                            if (done)
                            begin
                                init_step_next = 3'd2;
                                sw             = 1'b1;
                                sw_byte        = init_cmd(3'd1);
                            end
                        end
                        PH_POLL:
                        begin
                            if (!cmd.busy)
                            begin
                                phase_next      = PH_SETUP;
                                tick_count_next = 24'd0;
                                rs_next         = pending_rs_reg;
                                rw_next         = 1'b0;
                                en_next         = 1'b0;
                                drv_next        = 1'b0;
                                pin_byte_next   = 8'd0;
                            end
                        end
                        PH_SETUP:
                        begin
                            tick_count_next = cnt_inc;
                            if (done)
                            begin
                                tick_count_next = 24'd0;
                                phase_next      = PH_PULSE;
                                rs_next         = pending_rs_reg;
                                rw_next         = 1'b0;
                                en_next         = 1'b1;
                                drv_next        = 1'b1;
                                pin_byte_next   = pending_byte_reg;
                            end
                        end
                        PH_PULSE:
                        begin
                            tick_count_next = cnt_inc;
                            if (done)
                            begin
                                tick_count_next = 24'd0;
                                rs_next         = pending_rs_reg;
                                rw_next         = 1'b0;
                                en_next         = 1'b0;
                                drv_next        = 1'b1;
                                pin_byte_next   = pending_byte_reg;
                                if (init_step_reg == 3'd1)
                                begin
                                    phase_next = PH_GAP;
                                end
                                else if (init_step_reg >= 3'd2 && init_step_reg <= 3'd5)
                                begin
                                    init_step_next = init_step_reg + 3'd1;
                                    sw             = 1'b1;
                                    sw_byte        = init_cmd(init_step_reg);
                                end
                                else
                                begin
                                    init_step_next = 3'd0;
                                    phase_next     = PH_IDLE;
                                end
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                KIND_WRITE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        init_step_next = 3'd0;
                        sw             = 1'b1;
                    end
                end
                KIND_INIT:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        init_step_next  = 3'd0;
                        phase_next      = PH_POWER;
                        tick_count_next = 24'd0;
                    end
                end
                KIND_NONE: ;
            endcase
            if (sw)
            begin
                pending_byte_next = sw_byte;
                pending_rs_next   = (cmd.kind == KIND_WRITE) ? cmd.wr_rs : 1'b0;
                phase_next        = PH_POLL;
                tick_count_next   = 24'd0;
                rs_next           = 1'b0;
                rw_next           = 1'b1;
                en_next           = 1'b1;
                drv_next          = 1'b0;
                pin_byte_next     = 8'd0;
            end
        end
    end

    always_comb
    begin
        res_new.reg_select     = rs_next;
        res_new.read_not_write = rw_next;
        res_new.enable_pin     = en_next;
        res_new.bus_byte       = pin_byte_next;
        res_new.bus_drive      = drv_next;
        res_new.idle           = (phase_next == PH_IDLE);
        res_new.rejected       = rejected;
    end

    assign empty          = (res_count_reg == 2'd0);
    assign res_pop        = pop && !empty;
    assign rsp            = res_reg[res_rd_reg];
    assign res_count_next = res_count_reg + {1'b0, step} - {1'b0, res_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= 24'd0;
            pending_byte_reg <= 8'd0;
            pending_rs_reg   <= 1'b0;
            init_step_reg    <= 3'd0;
            rs_reg           <= 1'b1;
            rw_reg           <= 1'b0;
            en_reg           <= 1'b0;
            drv_reg          <= 1'b0;
            pin_byte_reg     <= 8'd0;
            res_wr_reg       <= 1'b0;
            res_rd_reg       <= 1'b0;
            res_count_reg    <= 2'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            pending_byte_reg <= pending_byte_next;
            pending_rs_reg   <= pending_rs_next;
            init_step_reg    <= init_step_next;
            rs_reg           <= rs_next;
            rw_reg           <= rw_next;
            en_reg           <= en_next;
            drv_reg          <= drv_next;
            pin_byte_reg     <= pin_byte_next;
            res_wr_reg       <= step ? ~res_wr_reg : res_wr_reg;
            res_rd_reg       <= res_pop ? ~res_rd_reg : res_rd_reg;
            res_count_reg    <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg[res_wr_reg] <= res_new;
        end
    end

endmodule

// ----- rtl/clbs_checker.sv -----
// Port-level checks for the character LCD bus sequencer, bound to the top level.
// Depends on clbs_pkg and char_lcd_bus_sequencer_unit.
`timescale 1ns / 1ps

module clbs_checker
    import clbs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input clbs_rsp_t rsp
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("Waiting result word vanished without pop.");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(rsp))
        else $error("Waiting result word changed without pop.");

    a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rsp.bus_drive |-> rsp.bus_byte == 8'd0)
        else $error("Data byte shown while the bus is released.");

    a_read_released: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.read_not_write |-> !rsp.bus_drive)
        else $error("Bus driven during a busy read.");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.rejected |-> !rsp.idle)
        else $error("Rejected request reported while idle.");

endmodule

bind char_lcd_bus_sequencer_unit clbs_checker u_clbs_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);

// ----- tb/sv/clbs_bus_checker.sv -----
// Checker for the character LCD bus sequencer: predicts the pin word for every accepted
// request word and compares it with each result word popped. Depends on clbs_pkg.
`timescale 1ns / 1ps

module clbs_bus_checker
    import clbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  clbs_req_t         req,
    input  logic              empty,
    input  logic              pop,
    input  clbs_rsp_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int unsigned       mismatches,
    output int unsigned       in_flight
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_POWER,
        SEQ_GAP,
        SEQ_POLL,
        SEQ_SETUP,
        SEQ_PULSE
    } seq_phase_t;

    localparam logic [47:0] INIT_BYTES = 48'h38_38_08_01_06_0C;

    clbs_cfg_t   cfg;
    seq_phase_t  seq_phase;
    logic [23:0] ticks;
    logic [7:0]  held_byte;
    logic        held_rs;
    logic [2:0]  init_pos;
    clbs_rsp_t   pins;
    clbs_rsp_t   pin_words[$];
    int unsigned miss_count;

    function automatic logic [7:0] init_byte(input logic [2:0] pos);
        return INIT_BYTES[8 * (6 - pos) +: 8];
    endfunction

    task automatic drive_pins(input logic rs, input logic rw, input logic en, input logic drv,
                              input logic [7:0] value);
        pins                = '0;
        pins.reg_select     = rs;
        pins.read_not_write = rw;
        pins.enable_pin     = en;
        pins.bus_drive      = drv;
        pins.bus_byte       = drv ? value : 8'h00;
    endtask

    task automatic begin_write(input logic [7:0] value, input logic rs);
        held_byte = value;
        held_rs   = rs;
        seq_phase = SEQ_POLL;
        ticks     = '0;
        drive_pins(1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
    endtask

    task automatic count_tick(input logic [23:0] len, output logic over);
        ticks = ticks + 24'd1;
        over  = (ticks >= len);
        if (over)
        begin
            ticks = '0;
        end
    endtask

    task automatic on_tick(input logic busy);
        logic over;
        case (seq_phase)
            SEQ_POWER:
            begin
                count_tick(cfg.power_up_ticks, over);
                if (over)
                begin
                    init_pos = 3'd1;
                    begin_write(init_byte(init_pos), 1'b0);
                end
            end
            SEQ_GAP:
            begin
                count_tick(cfg.init_gap_ticks, over);
                if (over)
                begin
                    init_pos = 3'd2;
                    begin_write(init_byte(init_pos), 1'b0);
                end
            end
            SEQ_POLL:
            begin
                if (!busy)
                begin
                    seq_phase = SEQ_SETUP;
                    ticks     = '0;
                    drive_pins(held_rs, 1'b0, 1'b0, 1'b0, 8'h00);
                end
            end
            SEQ_SETUP:
            begin
                count_tick({8'h00, cfg.setup_ticks}, over);
                if (over)
                begin
                    seq_phase = SEQ_PULSE;
                    drive_pins(held_rs, 1'b0, 1'b1, 1'b1, held_byte);
                end
            end
            SEQ_PULSE:
            begin
                count_tick({8'h00, cfg.pulse_ticks}, over);
                if (over)
                begin
                    drive_pins(held_rs, 1'b0, 1'b0, 1'b1, held_byte);
                    if (init_pos == 3'd1)
                    begin
                        seq_phase = SEQ_GAP;
                        ticks     = '0;
                    end
                    else if (init_pos >= 3'd2 && init_pos <= 3'd5)
                    begin
                        init_pos = init_pos + 3'd1;
                        begin_write(init_byte(init_pos), 1'b0);
                    end
                    else
                    begin
                        init_pos  = '0;
                        seq_phase = SEQ_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic step_lcd_bus(input clbs_req_t w, output clbs_rsp_t result);
        logic refused;
        refused = 1'b0;
        case (w.req_type)
            REQ_TICK:
            begin
                on_tick(w.busy_bit);
            end
            REQ_CMD, REQ_DATA, REQ_CURSOR, REQ_INIT:
            begin
                if (seq_phase != SEQ_IDLE)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    init_pos = '0;
                    case (w.req_type)
                        REQ_CMD:    begin_write(w.byte_value, 1'b0);
                        REQ_DATA:   begin_write(w.byte_value, 1'b1);
                        REQ_CURSOR: begin_write((w.row ? CMD_ROW1 : CMD_ROW0) + {2'b00, w.column},
                                                1'b0);
                        default:
                        begin
                            seq_phase = SEQ_POWER;
                            ticks     = '0;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        result          = pins;
        result.idle     = (seq_phase == SEQ_IDLE);
        result.rejected = refused;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            miss_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        clbs_rsp_t want;
        clbs_rsp_t predicted;
        if (!rst_n)
        begin
            cfg.setup_ticks    = SETUP_RESET;
            cfg.pulse_ticks    = PULSE_RESET;
            cfg.power_up_ticks = POWER_RESET;
            cfg.init_gap_ticks = GAP_RESET;
            seq_phase          = SEQ_IDLE;
            ticks              = '0;
            held_byte          = '0;
            held_rs            = 1'b0;
            init_pos           = '0;
            drive_pins(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
            pin_words.delete();
            miss_count         = 0;
            mismatches        <= 0;
            in_flight         <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SETUP: cfg.setup_ticks    = pwdata[15:0];
                    REG_PULSE: cfg.pulse_ticks    = pwdata[15:0];
                    REG_POWER: cfg.power_up_ticks = pwdata[23:0];
                    REG_GAP:   cfg.init_gap_ticks = pwdata[23:0];
                    default:
                    begin
                    end
                endcase
            end
            if (pop && !empty)
            begin
                if (pin_words.size() == 0)
                begin
                    $error("result word popped with no word expected");
                    miss_count++;
                end
                else
                begin
                    want = pin_words.pop_front();
                    check_field("reg_select", {7'd0, want.reg_select},
                                {7'd0, rsp.reg_select});
                    check_field("read_not_write", {7'd0, want.read_not_write},
                                {7'd0, rsp.read_not_write});
                    check_field("enable_pin", {7'd0, want.enable_pin},
                                {7'd0, rsp.enable_pin});
                    check_field("bus_byte", want.bus_byte, rsp.bus_byte);
                    check_field("bus_drive", {7'd0, want.bus_drive},
                                {7'd0, rsp.bus_drive});
                    check_field("idle", {7'd0, want.idle}, {7'd0, rsp.idle});
                    check_field("rejected", {7'd0, want.rejected}, {7'd0, rsp.rejected});
                end
            end
            if (push && !full)
            begin
                step_lcd_bus(req, predicted);
                pin_words.push_back(predicted);
            end
            mismatches <= miss_count;
            in_flight  <= unsigned'(pin_words.size());
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the sequencer testbench: clock, reset, register writes, request words and
// result stalls. Depends on clbs_pkg, char_lcd_bus_sequencer_unit and clbs_bus_checker.
`timescale 1ns / 1ps

module testbench;
    import clbs_pkg::*;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    clbs_req_t         req;
    logic              empty;
    logic              pop;
    clbs_rsp_t         rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int unsigned       mismatches;
    int unsigned       in_flight;

    int          burst_left;
    bit          steady;
    int          counted;
    int unsigned len_setup;
    int unsigned len_pulse;
    int unsigned len_power;
    int unsigned len_gap;

    char_lcd_bus_sequencer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    clbs_bus_checker bus_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req        (req),
        .empty      (empty),
        .pop        (pop),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic clbs_req_t any_word(input logic [2:0] kind);
        clbs_req_t w;
        w.req_type   = kind;
        w.byte_value = 8'($urandom);
        w.column     = 6'($urandom);
        w.row        = 1'($urandom);
        w.busy_bit   = 1'($urandom);
        return w;
    endfunction

    function automatic int unsigned poll_count();
        return ($urandom_range(3) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 1);
    endfunction

    task automatic send_word(input clbs_req_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push <= 1'b1;
        req  <= w;
        do @(posedge clk); while (full);
        burst_left--;
        if (w.req_type <= REQ_INIT)
        begin
            counted++;
        end
    endtask

    // Only called while the sequencer is busy, so any stray command, data, cursor or init request is refused.
    task automatic tick_word(input logic busy);
        clbs_req_t w;
        if ($urandom_range(11) == 0)
        begin
            send_word(any_word(3'($urandom_range(REQ_CMD, REQ_UNUSED_HI))));
        end
        w          = any_word(REQ_TICK);
        w.busy_bit = busy;
        send_word(w);
    endtask

    task automatic hold_ticks(input int unsigned n);
        repeat (n) tick_word(1'($urandom));
    endtask

    task automatic finish_write(input int unsigned polls);
        repeat (polls) tick_word(1'b1);
        tick_word(1'b0);
        hold_ticks(len_setup);
        hold_ticks(len_pulse);
    endtask

    task automatic lcd_write(input clbs_req_t w, input int unsigned polls);
        send_word(w);
        finish_write(polls);
    endtask

    task automatic lcd_init();
        send_word(any_word(REQ_INIT));
        hold_ticks(len_power);
        finish_write(poll_count());
        hold_ticks(len_gap);
        repeat (5) finish_write(poll_count());
    endtask

    task automatic drain_words();
        push       <= 1'b0;
        burst_left  = 0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_access(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_timing(input logic [31:0] setup_w, input logic [31:0] pulse_w,
                              input logic [31:0] power_w, input logic [31:0] gap_w);
        drain_words();
        reg_access(REG_SETUP, setup_w);
        reg_access(REG_PULSE, pulse_w);
        reg_access(REG_POWER, power_w);
        reg_access(REG_GAP, gap_w);
        psel    <= 1'b0;
        penable <= 1'b0;
        len_setup = (setup_w[15:0] == 0) ? 1 : setup_w[15:0];
        len_pulse = (pulse_w[15:0] == 0) ? 1 : pulse_w[15:0];
        len_power = (power_w[23:0] == 0) ? 1 : power_w[23:0];
        len_gap   = (gap_w[23:0] == 0) ? 1 : gap_w[23:0];
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            lcd_write(any_word(REQ_CMD), poll_count());
        end
        else if (pick < 65)
        begin
            lcd_write(any_word(REQ_DATA), poll_count());
        end
        else if (pick < 85)
        begin
            lcd_write(any_word(REQ_CURSOR), poll_count());
        end
        else if (pick < 93)
        begin
            lcd_init();
        end
        else if (pick[0])
        begin
            send_word(any_word(REQ_TICK));
        end
        else
        begin
            send_word(any_word(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))));
        end
    endtask

    initial
    begin : result_stalls
        int unsigned cycle;
        int          run_left;
        int unsigned rate;
        cycle    = 0;
        run_left = 0;
        rate     = 100;
        pop      = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 3000 == 1500)
            begin
                pop <= 1'b0;
                repeat (120) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(3))
                        0:       rate = 100;
                        1:       rate = 80;
                        2:       rate = 50;
                        default: rate = 20;
                    endcase
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                pop <= ($urandom_range(99) < rate);
            end
        end
    end

    initial
    begin : stimulus
        clbs_req_t w;
        rst_n      = 1'b0;
        push       = 1'b0;
        req        = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        steady     = 1'b0;
        counted    = 0;
        len_setup  = SETUP_RESET;
        len_pulse  = PULSE_RESET;
        len_power  = POWER_RESET;
        len_gap    = GAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lcd_write(any_word(REQ_DATA), 1);

        // Zero in every register must behave as a one-tick wait.
        set_timing(32'h0, 32'h0, 32'h0, 32'h0);
        w            = any_word(REQ_CMD);
        w.byte_value = 8'h00;
        send_word(w);
        send_word(any_word(REQ_DATA));
        send_word(any_word(REQ_UNUSED_HI));
        finish_write(2);
        send_word(any_word(REQ_TICK));
        send_word(any_word(REQ_UNUSED_LO));
        send_word(any_word(REQ_UNUSED_HI));
        w            = any_word(REQ_DATA);
        w.byte_value = 8'hFF;
        lcd_write(w, 0);
        w        = any_word(REQ_CURSOR);
        w.row    = 1'b1;
        w.column = 6'h3F;
        lcd_write(w, 0);
        w        = any_word(REQ_CURSOR);
        w.row    = 1'b0;
        w.column = 6'h00;
        lcd_write(w, 0);
        lcd_init();

        set_timing(32'd2, 32'd1, 32'd3, 32'd2);
        while (counted < 560) random_sequence();

        set_timing({16'($urandom), 16'($urandom_range(1, 6))},
                   {16'($urandom), 16'($urandom_range(1, 6))},
                   {8'($urandom), 24'($urandom_range(1, 30))},
                   {8'($urandom), 24'($urandom_range(1, 15))});
        while (counted < 1150) random_sequence();

        set_timing(32'hFFFF_0003, 32'hFFFF_0002, 32'hFF00_0004, 32'hFF00_0003);
        steady = 1'b1;
        lcd_write(any_word(REQ_DATA), 3);
        steady = 1'b0;
        drain_words();

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin : run_limit
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
